// ----- hdl/egt_pkg.sv -----
package egt_pkg;

  typedef struct packed {
    logic signed [15:0] red_in;
    logic signed [15:0] green_in;
    logic signed [15:0] blue_in;
    logic signed [15:0] alpha_in;
  } egt_in_t;

  typedef struct packed {
    logic signed [15:0] red_out;
    logic signed [15:0] green_out;
    logic signed [15:0] blue_out;
    logic signed [15:0] alpha_out;
    logic               applied;
  } egt_out_t;

  typedef enum logic [2:0] {
    REG_EXPOSURE_EV  = 3'd0,
    REG_GAMMA_ADJUST = 3'd1,
    REG_MIN_EXPOSURE = 3'd2,
    REG_MAX_EXPOSURE = 3'd3,
    REG_MIN_GAMMA    = 3'd4,
    REG_MAX_GAMMA    = 3'd5
  } egt_reg_t;

  typedef enum logic [1:0] {
    KIND_CALC = 2'd0,
    KIND_ZERO = 2'd1,
    KIND_ONE  = 2'd2
  } egt_kind_t;

  typedef struct packed {
    logic        pos;
    logic [3:0]  e;
    logic [15:0] frac;
  } egt_log_t;

  localparam logic signed [12:0] EXPOSURE_EV_RST  = 13'sd0;
  localparam logic        [11:0] GAMMA_ADJUST_RST = 12'd256;
  localparam logic signed [12:0] MIN_EXPOSURE_RST = -13'sd2560;
  localparam logic signed [12:0] MAX_EXPOSURE_RST = 13'sd2560;
  localparam logic        [11:0] MIN_GAMMA_RST    = 12'd64;
  localparam logic        [11:0] MAX_GAMMA_RST    = 12'd1024;

  localparam int LOG_STEPS = 16;
  localparam int DIV_BITS  = 29;
  localparam int EXP_STEPS = 16;
  localparam int LOG_LAT   = LOG_STEPS + 1;
  localparam int DIV_LAT   = DIV_BITS + 1;
  localparam int EXP_LAT   = EXP_STEPS + 1;
  localparam int LANE_LAT  = LOG_LAT + DIV_LAT + EXP_LAT + 1;

  localparam logic [15:0] Q_ONE       = 16'd4096;
  localparam logic [12:0] MAX_EXP_INT = 13'd14;

  function automatic logic [31:0] egt_isqrt(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] b;
    rem = v;
    res = '0;
    b   = 64'h4000_0000_0000_0000;
    for (int k = 0; k < 32; k++) begin
      if (rem >= res + b) begin
        rem = rem - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res[31:0];
  endfunction

  // Q.30 value of 2^(2^-idx), built the same way at every level.
  function automatic logic [31:0] egt_tab(input int idx);
    logic [31:0] t;
    t = 32'h8000_0000;
    for (int i = 1; i <= idx; i++) begin
      t = egt_isqrt({2'b00, t, 30'd0});
    end
    return t;
  endfunction

endpackage

// ----- hdl/exposure_gamma_transform.sv -----
// Channel   Handshake                 Payload
// input     start / busy              in_pixel  (egt_in_t)
// result    out_valid strobe          out_pixel (egt_out_t)
// config    cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One item is accepted every cycle while busy is low; new items enter before earlier ones leave.
// The datapath is the pipelined log2 squaring chain, the bit-per-stage
// divider for the exponent and the power-of-two multiplier chain.
// Reset is synchronous and active low; busy is set in reset and clears after rst_n rises.
// The receiver cannot stall, so the pipeline never holds.
module exposure_gamma_transform import egt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  egt_in_t     in_pixel,
  output logic        out_valid,
  output egt_out_t    out_pixel,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  localparam int TOT_LAT = LANE_LAT + 2;

  logic signed [12:0] exposure_ev_r;
  logic        [11:0] gamma_adjust_r;
  logic signed [12:0] min_exposure_r;
  logic signed [12:0] max_exposure_r;
  logic        [11:0] min_gamma_r;
  logic        [11:0] max_gamma_r;

  logic               busy_r;
  logic               vld0_r;
  egt_in_t            pix0_r;
  logic               ok0_r;
  logic               ok_nxt;

  logic signed [15:0] comp      [0:2];
  logic               lane_vld  [0:2];
  logic [15:0]        lane_res  [0:2];

  egt_in_t            pix_d_r   [1:LANE_LAT];
  logic               ok_d_r    [1:LANE_LAT];

  logic               out_valid_r;
  egt_out_t           out_pixel_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exposure_ev_r  <= EXPOSURE_EV_RST;
      gamma_adjust_r <= GAMMA_ADJUST_RST;
      min_exposure_r <= MIN_EXPOSURE_RST;
      max_exposure_r <= MAX_EXPOSURE_RST;
      min_gamma_r    <= MIN_GAMMA_RST;
      max_gamma_r    <= MAX_GAMMA_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (egt_reg_t'(cfg_index))
        REG_EXPOSURE_EV:  exposure_ev_r  <= cfg_data;
        REG_GAMMA_ADJUST: gamma_adjust_r <= cfg_data[11:0];
        REG_MIN_EXPOSURE: min_exposure_r <= cfg_data;
        REG_MAX_EXPOSURE: max_exposure_r <= cfg_data;
        REG_MIN_GAMMA:    min_gamma_r    <= cfg_data[11:0];
        REG_MAX_GAMMA:    max_gamma_r    <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy = busy_r;

  assign ok_nxt = (exposure_ev_r >= min_exposure_r) && (exposure_ev_r <= max_exposure_r) &&
                  (gamma_adjust_r >= min_gamma_r) && (gamma_adjust_r <= max_gamma_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else begin
      vld0_r <= start && !busy_r;
    end
  end

  always_ff @(posedge clk) begin
    pix0_r <= in_pixel;
    ok0_r  <= ok_nxt;
  end

  assign comp[0] = pix0_r.red_in;
  assign comp[1] = pix0_r.green_in;
  assign comp[2] = pix0_r.blue_in;

  for (genvar c = 0; c < 3; c++) begin : g_lane
    egt_lane u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_vld  (vld0_r),
      .in_comp (comp[c]),
      .ev      (exposure_ev_r),
      .gam     (gamma_adjust_r),
      .out_vld (lane_vld[c]),
      .out_res (lane_res[c])
    );
  end

  always_ff @(posedge clk) begin
    pix_d_r[1] <= pix0_r;
    ok_d_r[1]  <= ok0_r;
  end

  for (genvar k = 2; k <= LANE_LAT; k++) begin : g_dly
    always_ff @(posedge clk) begin
      pix_d_r[k] <= pix_d_r[k-1];
      ok_d_r[k]  <= ok_d_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= lane_vld[0];
    end
  end

  always_ff @(posedge clk) begin
    out_pixel_r.alpha_out <= pix_d_r[LANE_LAT].alpha_in;
    out_pixel_r.applied   <= ok_d_r[LANE_LAT];
    if (ok_d_r[LANE_LAT]) begin
      out_pixel_r.red_out   <= lane_res[0];
      out_pixel_r.green_out <= lane_res[1];
      out_pixel_r.blue_out  <= lane_res[2];
    end else begin
      out_pixel_r.red_out   <= pix_d_r[LANE_LAT].red_in;
      out_pixel_r.green_out <= pix_d_r[LANE_LAT].green_in;
      out_pixel_r.blue_out  <= pix_d_r[LANE_LAT].blue_in;
    end
  end

  assign out_valid = out_valid_r;
  assign out_pixel = out_pixel_r;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##TOT_LAT out_valid)
    else $error("item did not produce a result at the pipeline latency");

  a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (lane_vld[0] == lane_vld[1]) && (lane_vld[1] == lane_vld[2]))
    else $error("color lanes lost alignment");

  a_applied_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_pixel.applied) |->
      (out_pixel.red_out >= 16'sd0) && (out_pixel.red_out <= 16'sd4096) &&
      (out_pixel.green_out >= 16'sd0) && (out_pixel.green_out <= 16'sd4096) &&
      (out_pixel.blue_out >= 16'sd0) && (out_pixel.blue_out <= 16'sd4096))
    else $error("transformed component outside the unit range");

endmodule

// ----- hdl/egt_log2.sv -----
module egt_log2 import egt_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  logic signed [15:0] in_comp,
  output logic               out_vld,
  output egt_log_t           out_log
);

  logic        vld_r  [0:LOG_STEPS];
  logic        pos_r  [0:LOG_STEPS];
  logic [3:0]  e_r    [0:LOG_STEPS];
  logic [30:0] m_r    [0:LOG_STEPS];
  logic [15:0] frac_r [0:LOG_STEPS];

  logic [3:0]  e_nxt;
  logic [30:0] m_nxt;
  logic        pos_nxt;

  always_comb begin
    e_nxt = '0;
    for (int k = 1; k < 15; k++) begin
      if (in_comp[k]) begin
        e_nxt = 4'(k);
      end
    end
    m_nxt   = {16'd0, in_comp[14:0]} << (5'd30 - {1'b0, e_nxt});
    pos_nxt = !in_comp[15] && (in_comp != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    pos_r[0]  <= pos_nxt;
    e_r[0]    <= e_nxt;
    m_r[0]    <= m_nxt;
    frac_r[0] <= '0;
  end

  for (genvar k = 1; k <= LOG_STEPS; k++) begin : g_sq
    logic [61:0] prod;
    logic [31:0] sq;

    assign prod = 62'(m_r[k-1]) * 62'(m_r[k-1]);
    assign sq   = prod[61:30];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      pos_r[k]  <= pos_r[k-1];
      e_r[k]    <= e_r[k-1];
      m_r[k]    <= sq[31] ? sq[31:1] : sq[30:0];
      frac_r[k] <= {frac_r[k-1][14:0], sq[31]};
    end
  end

  assign out_vld      = vld_r[LOG_STEPS];
  assign out_log.pos  = pos_r[LOG_STEPS];
  assign out_log.e    = e_r[LOG_STEPS];
  assign out_log.frac = frac_r[LOG_STEPS];

endmodule

// ----- hdl/egt_div.sv -----
module egt_div import egt_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_vld,
  input  egt_kind_t           in_kind,
  input  logic [DIV_BITS-1:0] in_num,
  input  logic [11:0]         gam,
  output logic                out_vld,
  output egt_kind_t           out_kind,
  output logic [DIV_BITS-1:0] out_quo
);

  logic                vld_r  [0:DIV_BITS];
  egt_kind_t           kind_r [0:DIV_BITS];
  logic [11:0]         rem_r  [0:DIV_BITS];
  logic [DIV_BITS-1:0] num_r  [0:DIV_BITS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    kind_r[0] <= in_kind;
    rem_r[0]  <= '0;
    num_r[0]  <= in_num;
  end

  for (genvar k = 1; k <= DIV_BITS; k++) begin : g_bit
    logic [12:0] trial;
    logic        take;

    assign trial = {rem_r[k-1], num_r[k-1][DIV_BITS-1]};
    assign take  = trial >= {1'b0, gam};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      kind_r[k] <= kind_r[k-1];
      rem_r[k]  <= take ? 12'(trial - {1'b0, gam}) : trial[11:0];
      num_r[k]  <= {num_r[k-1][DIV_BITS-2:0], take};
    end
  end

  assign out_vld  = vld_r[DIV_BITS];
  assign out_kind = kind_r[DIV_BITS];
  assign out_quo  = num_r[DIV_BITS];

endmodule

// ----- hdl/egt_exp2.sv -----
module egt_exp2 import egt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_vld,
  input  egt_kind_t   in_kind,
  input  logic [15:0] in_g,
  input  logic [3:0]  in_q,
  output logic        out_vld,
  output egt_kind_t   out_kind,
  output logic [3:0]  out_q,
  output logic [30:0] out_acc
);

  logic        vld_r  [0:EXP_STEPS];
  egt_kind_t   kind_r [0:EXP_STEPS];
  logic [15:0] g_r    [0:EXP_STEPS];
  logic [3:0]  q_r    [0:EXP_STEPS];
  logic [30:0] acc_r  [0:EXP_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    kind_r[0] <= in_kind;
    g_r[0]    <= in_g;
    q_r[0]    <= in_q;
    acc_r[0]  <= 31'h4000_0000;
  end

  for (genvar k = 1; k <= EXP_STEPS; k++) begin : g_mul
    localparam logic [30:0] TV = 31'(egt_tab(k));
    logic [61:0] prod;

    assign prod = 62'(acc_r[k-1]) * 62'(TV);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      kind_r[k] <= kind_r[k-1];
      g_r[k]    <= g_r[k-1];
      q_r[k]    <= q_r[k-1];
      acc_r[k]  <= g_r[k-1][EXP_STEPS-k] ? prod[60:30] : acc_r[k-1];
    end
  end

  assign out_vld  = vld_r[EXP_STEPS];
  assign out_kind = kind_r[EXP_STEPS];
  assign out_q    = q_r[EXP_STEPS];
  assign out_acc  = acc_r[EXP_STEPS];

endmodule

// ----- hdl/egt_lane.sv -----
module egt_lane import egt_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  logic signed [15:0] in_comp,
  input  logic signed [12:0] ev,
  input  logic [11:0]        gam,
  output logic               out_vld,
  output logic [15:0]        out_res
);

  logic                log_vld;
  egt_log_t            log_val;
  logic                div_vld;
  egt_kind_t           div_kind;
  logic [DIV_BITS-1:0] div_quo;
  logic                exp_vld;
  egt_kind_t           exp_kind;
  logic [3:0]          exp_q;
  logic [30:0]         exp_acc;

  logic signed [22:0]  lg;
  logic [22:0]         neg_lg;
  logic [DIV_BITS-1:0] num;
  egt_kind_t           lg_kind;

  egt_kind_t           mag_kind;
  logic [3:0]          q_nxt;
  logic [15:0]         g_nxt;

  logic [5:0]          sh;
  logic [31:0]         rsum;
  logic [31:0]         rshift;
  logic [15:0]         res_nxt;

  logic                vld_r;
  logic [15:0]         res_r;

  egt_log2 u_log2 (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (in_vld),
    .in_comp (in_comp),
    .out_vld (log_vld),
    .out_log (log_val)
  );

  always_comb begin
    lg = 23'(signed'({{2'b00, log_val.e} - 6'd12, log_val.frac}))
       + 23'(signed'({ev, 8'd0}));
    neg_lg = 23'(-lg);
    num    = 29'({neg_lg[20:0], 8'd0}) + 29'(gam >> 1);
    if (!log_val.pos) begin
      lg_kind = KIND_ZERO;
    end else if (!lg[22]) begin
      lg_kind = KIND_ONE;
    end else if (gam == '0) begin
      lg_kind = KIND_ZERO;
    end else begin
      lg_kind = KIND_CALC;
    end
  end

  egt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (log_vld),
    .in_kind  (lg_kind),
    .in_num   (num),
    .gam      (gam),
    .out_vld  (div_vld),
    .out_kind (div_kind),
    .out_quo  (div_quo)
  );

  always_comb begin
    q_nxt = div_quo[19:16] + 4'(div_quo[15:0] != '0);
    g_nxt = 16'(17'h10000 - {1'b0, div_quo[15:0]});
    if (div_kind != KIND_CALC) begin
      mag_kind = div_kind;
    end else if (div_quo == '0) begin
      mag_kind = KIND_ONE;
    end else if (div_quo[DIV_BITS-1:16] >= MAX_EXP_INT) begin
      mag_kind = KIND_ZERO;
    end else begin
      mag_kind = KIND_CALC;
    end
  end

  egt_exp2 u_exp2 (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (div_vld),
    .in_kind  (mag_kind),
    .in_g     (g_nxt),
    .in_q     (q_nxt),
    .out_vld  (exp_vld),
    .out_kind (exp_kind),
    .out_q    (exp_q),
    .out_acc  (exp_acc)
  );

  always_comb begin
    sh     = 6'd18 + {2'b00, exp_q};
    rsum   = {1'b0, exp_acc} + (32'd1 << (sh - 6'd1));
    rshift = rsum >> sh;
    case (exp_kind)
      KIND_ZERO: res_nxt = '0;
      KIND_ONE:  res_nxt = Q_ONE;
      KIND_CALC: res_nxt = rshift[15:0];
      default:   res_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= exp_vld;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_vld = vld_r;
  assign out_res = res_r;

endmodule
